// File: rtl/core/acpc_pkg.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller package
// Shared item types, configuration record and code constants.
// ----------------------------------------------------------------------------
package acpc_pkg;

  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned LIMIT_W = 10;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned LOCK_W  = 2;
  localparam int unsigned DRIVE_W = 2;
  localparam int unsigned PORT_W  = 3;
  localparam int unsigned LCMD_W  = 2;
  localparam int unsigned DEB_W   = 4;
  localparam int unsigned HOLD_W  = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_STANDALONE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHG_EN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd4;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 4'd5;
  localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 8'd150;
  localparam logic [HOLD_W-1:0] TIMER_MAX    = 8'hFF;

  localparam logic [DUTY_W-1:0] DUTY_LOW      = 7'd8;
  localparam logic [DUTY_W-1:0] DUTY_LINEAR   = 7'd10;
  localparam logic [DUTY_W-1:0] DUTY_STEEP    = 7'd85;
  localparam logic [DUTY_W-1:0] DUTY_STEEP_HI = 7'd96;
  localparam logic [DUTY_W-1:0] DUTY_TOP      = 7'd97;
  localparam logic [DUTY_W-1:0] DUTY_OFFSET   = 7'd64;
  localparam logic [DUTY_W-1:0] DUTY_UNPLUG   = 7'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN       = 10'd60;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX       = 10'd800;
  localparam logic [LIMIT_W-1:0] LIMIT_LIN_SCALE = 10'd6;
  localparam logic [LIMIT_W-1:0] LIMIT_STP_SCALE = 10'd25;

  localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_LOCK     = 3'd1;
  localparam logic [STATE_W-1:0] ST_CHARGE   = 3'd2;
  localparam logic [STATE_W-1:0] ST_PAUSE    = 3'd3;
  localparam logic [STATE_W-1:0] ST_COMPLETE = 3'd4;
  localparam logic [STATE_W-1:0] ST_ERROR    = 3'd5;

  localparam logic [LOCK_W-1:0] LK_OPEN   = 2'd0;
  localparam logic [LOCK_W-1:0] LK_CLOSED = 2'd1;

  localparam logic [DRIVE_W-1:0] DRV_NONE = 2'd0;
  localparam logic [DRIVE_W-1:0] DRV_B    = 2'd1;
  localparam logic [DRIVE_W-1:0] DRV_C    = 2'd2;

  localparam logic [PORT_W-1:0] PS_NONE      = 3'd0;
  localparam logic [PORT_W-1:0] PS_AVAILABLE = 3'd1;
  localparam logic [PORT_W-1:0] PS_ERR       = 3'd2;
  localparam logic [PORT_W-1:0] PS_CHG_AC    = 3'd3;
  localparam logic [PORT_W-1:0] PS_PLUGGED   = 3'd4;
  localparam logic [PORT_W-1:0] PS_IDLE      = 3'd5;

  localparam logic [LCMD_W-1:0] LC_NONE   = 2'd0;
  localparam logic [LCMD_W-1:0] LC_LOCK   = 2'd1;
  localparam logic [LCMD_W-1:0] LC_UNLOCK = 2'd2;

  typedef struct packed {
    logic [DUTY_W-1:0]  duty_percent;
    logic               button_held;
    logic [LOCK_W-1:0]  lock_status;
    logic               plug_detected;
    logic               dc_session_idle;
    logic [STATE_W-1:0] charger_request;
    logic               request_valid;
  } in_item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] current_limit_deciamp;
    logic               basic_ac_mode;
    logic [DRIVE_W-1:0] pilot_drive;
    logic [PORT_W-1:0]  port_status;
    logic [LCMD_W-1:0]  lock_command;
    logic [STATE_W-1:0] applied_state;
  } res_item_t;

  typedef struct packed {
    logic              standalone_mode;
    logic              charging_enabled;
    logic              unlock_allowed;
    logic [DEB_W-1:0]  debounce_ticks;
    logic [HOLD_W-1:0] button_holdoff_ticks;
  } cfg_t;

endpackage

// File: rtl/core/acpc_if.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller channels
// Valid/ready channels for the tick items and the result items.
// ----------------------------------------------------------------------------
interface acpc_in_if
  import acpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [DUTY_W-1:0]  duty_percent;
  logic               button_held;
  logic [LOCK_W-1:0]  lock_status;
  logic               plug_detected;
  logic               dc_session_idle;
  logic [STATE_W-1:0] charger_request;
  logic               request_valid;

  modport source (
    output valid, duty_percent, button_held, lock_status, plug_detected,
           dc_session_idle, charger_request, request_valid,
    input  ready
  );
  modport sink (
    input  valid, duty_percent, button_held, lock_status, plug_detected,
           dc_session_idle, charger_request, request_valid,
    output ready
  );
endinterface

interface acpc_out_if
  import acpc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] current_limit_deciamp;
  logic               basic_ac_mode;
  logic [DRIVE_W-1:0] pilot_drive;
  logic [PORT_W-1:0]  port_status;
  logic [LCMD_W-1:0]  lock_command;
  logic [STATE_W-1:0] applied_state;

  modport source (
    output valid, current_limit_deciamp, basic_ac_mode, pilot_drive,
           port_status, lock_command, applied_state,
    input  ready
  );
  modport sink (
    input  valid, current_limit_deciamp, basic_ac_mode, pilot_drive,
           port_status, lock_command, applied_state,
    output ready
  );
endinterface

// File: rtl/core/ac_pilot_charge_controller.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller
// An accepted tick item is registered in in_r, then its result in out_r.
// Throughput: one item per cycle; while a result stalls, one more item waits
// in the input register and then the input channel stalls.
// Reset: synchronous active-low; clears the valid flags and all core state and
// loads the configuration defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ac_pilot_charge_controller
  import acpc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  acpc_in_if.sink               in_chan,
  acpc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t      cfg_r;
  in_item_t  in_r;
  logic      in_vld_r;
  res_item_t out_r;
  logic      out_vld_r;
  res_item_t res;
  logic      step;
  logic      in_acc;

  assign step          = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || step;
  assign in_acc        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.standalone_mode      <= 1'b0;
      cfg_r.charging_enabled     <= 1'b1;
      cfg_r.unlock_allowed       <= 1'b1;
      cfg_r.debounce_ticks       <= DEBOUNCE_RST;
      cfg_r.button_holdoff_ticks <= HOLDOFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STANDALONE: cfg_r.standalone_mode      <= cfg_wdata[0];
        CFG_CHG_EN:     cfg_r.charging_enabled     <= cfg_wdata[0];
        CFG_UNLOCK_EN:  cfg_r.unlock_allowed       <= cfg_wdata[0];
        CFG_DEBOUNCE:   cfg_r.debounce_ticks       <= cfg_wdata[DEB_W-1:0];
        CFG_HOLDOFF:    cfg_r.button_holdoff_ticks <= cfg_wdata[HOLD_W-1:0];
        default:        cfg_r                      <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r.duty_percent    <= in_chan.duty_percent;
      in_r.button_held     <= in_chan.button_held;
      in_r.lock_status     <= in_chan.lock_status;
      in_r.plug_detected   <= in_chan.plug_detected;
      in_r.dc_session_idle <= in_chan.dc_session_idle;
      in_r.charger_request <= in_chan.charger_request;
      in_r.request_valid   <= in_chan.request_valid;
    end
  end

  acpc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg_r),
    .item  (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_chan.valid                 = out_vld_r;
  assign out_chan.current_limit_deciamp = out_r.current_limit_deciamp;
  assign out_chan.basic_ac_mode         = out_r.basic_ac_mode;
  assign out_chan.pilot_drive           = out_r.pilot_drive;
  assign out_chan.port_status           = out_r.port_status;
  assign out_chan.lock_command          = out_r.lock_command;
  assign out_chan.applied_state         = out_r.applied_state;

endmodule

// File: rtl/core/acpc_limit.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller current limit
// Maps the pilot duty in percent to the current limit in tenths of an ampere.
// ----------------------------------------------------------------------------
module acpc_limit
  import acpc_pkg::*;
(
  input  logic [DUTY_W-1:0]  duty,
  output logic [LIMIT_W-1:0] limit
);

  logic [LIMIT_W-1:0] duty_ext;
  logic [LIMIT_W-1:0] lin_val;
  logic [LIMIT_W-1:0] stp_val;

  assign duty_ext = LIMIT_W'(duty);
  assign lin_val  = LIMIT_W'(duty_ext * LIMIT_LIN_SCALE);
  assign stp_val  = LIMIT_W'((duty_ext - LIMIT_W'(DUTY_OFFSET)) * LIMIT_STP_SCALE);

  always_comb begin
    priority if (duty < DUTY_LOW) begin
      limit = '0;
    end else if (duty < DUTY_LINEAR) begin
      limit = LIMIT_MIN;
    end else if (duty < DUTY_STEEP) begin
      limit = lin_val;
    end else if (duty <= DUTY_STEEP_HI) begin
      limit = stp_val;
    end else if (duty == DUTY_TOP) begin
      limit = LIMIT_MAX;
    end else begin
      limit = '0;
    end
  end

endmodule

// File: rtl/core/acpc_core.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller decision core
// Debounce counters, button hold-off and the per-tick charger decision.
// ----------------------------------------------------------------------------
module acpc_core
  import acpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  cfg_t      cfg,
  input  in_item_t  item,
  output res_item_t res
);

  logic [DEB_W-1:0]   low_cnt_r, low_cnt_nxt;
  logic [DEB_W-1:0]   pwm_cnt_r, pwm_cnt_nxt;
  logic               flag_r, flag_nxt;
  logic               block_r, block_nxt;
  logic [HOLD_W-1:0]  timer_r, timer_nxt;
  logic [STATE_W-1:0] req_r, req_nxt;
  logic [STATE_W-1:0] applied_r, applied_nxt;
  logic [STATE_W-1:0] act;
  logic [LIMIT_W-1:0] limit;
  logic               low_duty;
  logic [DRIVE_W-1:0] drive;
  logic [PORT_W-1:0]  port;
  logic [LCMD_W-1:0]  lcmd;
  logic               lk_open;
  logic               lk_closed;

  acpc_limit u_limit (
    .duty  (item.duty_percent),
    .limit (limit)
  );

  assign low_duty  = item.duty_percent < DUTY_LOW;
  assign lk_open   = item.lock_status == LK_OPEN;
  assign lk_closed = item.lock_status == LK_CLOSED;

  always_comb begin
    req_nxt     = item.request_valid ? item.charger_request : req_r;
    low_cnt_nxt = low_cnt_r;
    pwm_cnt_nxt = pwm_cnt_r;
    flag_nxt    = flag_r;
    if (low_duty) begin
      if (low_cnt_r < cfg.debounce_ticks) begin
        low_cnt_nxt = low_cnt_r + DEB_W'(1);
      end else begin
        flag_nxt = 1'b0;
        if (cfg.standalone_mode) begin
          req_nxt = ST_COMPLETE;
        end
      end
    end else begin
      low_cnt_nxt = '0;
    end
    if (limit != '0) begin
      if (pwm_cnt_r < cfg.debounce_ticks) begin
        pwm_cnt_nxt = pwm_cnt_r + DEB_W'(1);
      end else begin
        flag_nxt = 1'b1;
        if (cfg.standalone_mode) begin
          req_nxt = ST_CHARGE;
        end
      end
    end else begin
      pwm_cnt_nxt = '0;
    end

    act         = req_nxt;
    block_nxt   = block_r;
    timer_nxt   = timer_r;
    applied_nxt = applied_r;
    drive       = DRV_NONE;
    port        = PS_NONE;
    lcmd        = LC_NONE;
    if (flag_nxt) begin
      if (item.button_held && act != ST_IDLE) begin
        act       = ST_IDLE;
        block_nxt = 1'b1;
        timer_nxt = '0;
      end
      if (block_nxt) begin
        act = ST_IDLE;
        if (timer_nxt != TIMER_MAX) begin
          timer_nxt = timer_nxt + HOLD_W'(1);
        end
        if (timer_nxt > cfg.button_holdoff_ticks || timer_nxt == TIMER_MAX) begin
          block_nxt = 1'b0;
        end
      end
      if (!cfg.charging_enabled) begin
        act = ST_IDLE;
      end
      unique case (act)
        ST_IDLE: begin
          drive = DRV_B;
          port  = PS_AVAILABLE;
          if (lk_closed && cfg.unlock_allowed) begin
            lcmd = LC_UNLOCK;
          end
        end
        ST_LOCK: begin
          if (lk_open) begin
            lcmd = LC_LOCK;
          end
        end
        ST_ERROR: begin
          port = PS_ERR;
        end
        ST_COMPLETE: begin
          drive = DRV_B;
        end
        ST_CHARGE: begin
          if (lk_open) begin
            lcmd = LC_LOCK;
          end
          if (lk_closed) begin
            drive = DRV_C;
            port  = PS_CHG_AC;
          end
        end
        default: begin
          drive = DRV_NONE;
        end
      endcase
      applied_nxt = act;
    end else if (item.plug_detected && item.dc_session_idle) begin
      port = PS_PLUGGED;
      if (item.duty_percent < DUTY_UNPLUG && lk_closed && cfg.unlock_allowed) begin
        lcmd = LC_UNLOCK;
      end
    end else if (!item.plug_detected && item.dc_session_idle) begin
      drive = DRV_B;
      port  = PS_IDLE;
      if (lk_closed) begin
        lcmd = LC_UNLOCK;
      end
    end
  end

  always_comb begin
    res.current_limit_deciamp = limit;
    res.basic_ac_mode         = flag_nxt;
    res.pilot_drive           = drive;
    res.port_status           = port;
    res.lock_command          = lcmd;
    res.applied_state         = applied_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_cnt_r <= '0;
      pwm_cnt_r <= '0;
      flag_r    <= 1'b0;
      block_r   <= 1'b0;
      timer_r   <= '0;
      req_r     <= ST_IDLE;
      applied_r <= ST_IDLE;
    end else if (step) begin
      low_cnt_r <= low_cnt_nxt;
      pwm_cnt_r <= pwm_cnt_nxt;
      flag_r    <= flag_nxt;
      block_r   <= block_nxt;
      timer_r   <= timer_nxt;
      req_r     <= req_nxt;
      applied_r <= applied_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(timer_r) && $stable(req_r) && $stable(applied_r) && $stable(flag_r))
    else $error("controller state changed without an item");

  a_low_duty_clears_pwm: assert property (@(posedge clk) disable iff (!rst_n)
    step && low_duty |=> pwm_cnt_r == '0)
    else $error("valid PWM counter not cleared on low duty");

  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && flag_nxt && !cfg.charging_enabled |=> applied_r == ST_IDLE)
    else $error("charging disabled but a non-idle state was applied");

  a_block_forces_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && block_r && flag_nxt |=> applied_r == ST_IDLE)
    else $error("button hold-off active but a non-idle state was applied");
`endif

endmodule

// File: dv/ac_pilot_charge_controller_test.sv
// ----------------------------------------------------------------------------
// AC pilot charge controller testbench
// Sends pilot tick items through the input channel and checks every result
// item against a cycle-free predictor of the controller kept in this module.
// Both channels idle and stall at random, and the configuration registers
// are rewritten between phases while the controller is idle.
// ----------------------------------------------------------------------------
module ac_pilot_charge_controller_test;
  import acpc_pkg::*;

  localparam logic [LOCK_W-1:0] LK_MOVING  = 2'd2;
  localparam logic [LOCK_W-1:0] LK_UNKNOWN = 2'd3;
  localparam int RUN_PWM   = 0;
  localparam int RUN_LOW   = 1;
  localparam int RUN_NOISE = 2;
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  acpc_in_if  in_ch ();
  acpc_out_if out_ch ();

  ac_pilot_charge_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cfg_t               settings;
  logic [DEB_W-1:0]   low_duty_ticks;
  logic [DEB_W-1:0]   pwm_ticks;
  logic               ac_mode;
  logic               stop_block;
  logic [HOLD_W-1:0]  stop_timer;
  logic [STATE_W-1:0] req_state;
  logic [STATE_W-1:0] act_state;

  res_item_t predicted_results[$];
  int        mismatch_count;
  bit        sender_gaps;
  bit        receiver_stalls;
  int        result_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [LIMIT_W-1:0] duty_limit(logic [DUTY_W-1:0] d);
    if (d < DUTY_LOW) return '0;
    if (d < DUTY_LINEAR) return LIMIT_MIN;
    if (d < DUTY_STEEP) return LIMIT_W'(d) * LIMIT_LIN_SCALE;
    if (d <= DUTY_STEEP_HI) return (LIMIT_W'(d) - LIMIT_W'(DUTY_OFFSET)) * LIMIT_STP_SCALE;
    if (d == DUTY_TOP) return LIMIT_MAX;
    return '0;
  endfunction

  function automatic res_item_t predict_tick(in_item_t t);
    res_item_t          r;
    logic [STATE_W-1:0] act;
    logic [LIMIT_W-1:0] lim;
    r = '0;
    r.pilot_drive  = DRV_NONE;
    r.port_status  = PS_NONE;
    r.lock_command = LC_NONE;
    if (t.request_valid) req_state = t.charger_request;
    lim = duty_limit(t.duty_percent);

    if (t.duty_percent < DUTY_LOW) begin
      if (low_duty_ticks < settings.debounce_ticks) begin
        low_duty_ticks = low_duty_ticks + DEB_W'(1);
      end else begin
        ac_mode = 1'b0;
        if (settings.standalone_mode) req_state = ST_COMPLETE;
      end
    end else begin
      low_duty_ticks = '0;
    end

    if (lim != '0) begin
      if (pwm_ticks < settings.debounce_ticks) begin
        pwm_ticks = pwm_ticks + DEB_W'(1);
      end else begin
        ac_mode = 1'b1;
        if (settings.standalone_mode) req_state = ST_CHARGE;
      end
    end else begin
      pwm_ticks = '0;
    end

    if (ac_mode) begin
      act = req_state;
      if (t.button_held && act != ST_IDLE) begin
        act = ST_IDLE;
        stop_block = 1'b1;
        stop_timer = '0;
      end
      if (stop_block) begin
        act = ST_IDLE;
        if (stop_timer != TIMER_MAX) stop_timer = stop_timer + HOLD_W'(1);
        if (stop_timer > settings.button_holdoff_ticks || stop_timer == TIMER_MAX)
          stop_block = 1'b0;
      end
      if (!settings.charging_enabled) act = ST_IDLE;
      case (act)
        ST_IDLE: begin
          r.pilot_drive = DRV_B;
          r.port_status = PS_AVAILABLE;
          if (t.lock_status == LK_CLOSED && settings.unlock_allowed)
            r.lock_command = LC_UNLOCK;
        end
        ST_LOCK: begin
          if (t.lock_status == LK_OPEN) r.lock_command = LC_LOCK;
        end
        ST_ERROR: begin
          r.port_status = PS_ERR;
        end
        ST_COMPLETE: begin
          r.pilot_drive = DRV_B;
        end
        ST_CHARGE: begin
          if (t.lock_status == LK_OPEN) r.lock_command = LC_LOCK;
          if (t.lock_status == LK_CLOSED) begin
            r.pilot_drive = DRV_C;
            r.port_status = PS_CHG_AC;
          end
        end
        default: begin
        end
      endcase
      act_state = act;
    end else if (t.plug_detected && t.dc_session_idle) begin
      r.port_status = PS_PLUGGED;
      if (t.duty_percent < DUTY_UNPLUG && t.lock_status == LK_CLOSED &&
          settings.unlock_allowed)
        r.lock_command = LC_UNLOCK;
    end else if (!t.plug_detected && t.dc_session_idle) begin
      r.pilot_drive = DRV_B;
      r.port_status = PS_IDLE;
      if (t.lock_status == LK_CLOSED) r.lock_command = LC_UNLOCK;
    end

    r.current_limit_deciamp = lim;
    r.basic_ac_mode         = ac_mode;
    r.applied_state         = act_state;
    return r;
  endfunction

  function automatic in_item_t make_tick(int duty, bit button, logic [LOCK_W-1:0] lock,
                                         bit plug, bit dc_idle,
                                         logic [STATE_W-1:0] req, bit req_valid);
    in_item_t t;
    t.duty_percent    = DUTY_W'(duty);
    t.button_held     = button;
    t.lock_status     = lock;
    t.plug_detected   = plug;
    t.dc_session_idle = dc_idle;
    t.charger_request = req;
    t.request_valid   = req_valid;
    return t;
  endfunction

  function automatic in_item_t draw_tick(int run_kind);
    int                 duty;
    logic [STATE_W-1:0] req;
    case (run_kind)
      RUN_PWM: duty = $urandom_range(8, 97);
      RUN_LOW: duty = $urandom_range(0, 7);
      default: duty = $urandom_range(0, 127);
    endcase
    req = ($urandom_range(0, 2) == 0) ? STATE_W'($urandom_range(0, 7)) : ST_CHARGE;
    return make_tick(duty, $urandom_range(0, 15) == 0, LOCK_W'($urandom_range(0, 3)),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0, req,
                     $urandom_range(0, 3) == 0);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_item_t got;
    res_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.current_limit_deciamp = out_ch.current_limit_deciamp;
      got.basic_ac_mode         = out_ch.basic_ac_mode;
      got.pilot_drive           = out_ch.pilot_drive;
      got.port_status           = out_ch.port_status;
      got.lock_command          = out_ch.lock_command;
      got.applied_state         = out_ch.applied_state;
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        check_field("current_limit_deciamp", want.current_limit_deciamp,
                    got.current_limit_deciamp);
        check_field("basic_ac_mode", want.basic_ac_mode, got.basic_ac_mode);
        check_field("pilot_drive", want.pilot_drive, got.pilot_drive);
        check_field("port_status", want.port_status, got.port_status);
        check_field("lock_command", want.lock_command, got.lock_command);
        check_field("applied_state", want.applied_state, got.applied_state);
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = receiver_stalls ? $urandom_range(0, 19) : 0;
      if (result_hold_cycles > 0) begin
        stall = stall + result_hold_cycles;
        result_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic send_tick(in_item_t t);
    int gap;
    gap = sender_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.duty_percent    <= t.duty_percent;
    in_ch.button_held     <= t.button_held;
    in_ch.lock_status     <= t.lock_status;
    in_ch.plug_detected   <= t.plug_detected;
    in_ch.dc_session_idle <= t.dc_session_idle;
    in_ch.charger_request <= t.charger_request;
    in_ch.request_valid   <= t.request_valid;
    do @(posedge clk); while (!in_ch.ready);
    predicted_results.push_back(predict_tick(t));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STANDALONE;
    cfg_wdata <= CFG_DATA_W'(c.standalone_mode);
    @(posedge clk);
    cfg_index <= CFG_CHG_EN;
    cfg_wdata <= CFG_DATA_W'(c.charging_enabled);
    @(posedge clk);
    cfg_index <= CFG_UNLOCK_EN;
    cfg_wdata <= CFG_DATA_W'(c.unlock_allowed);
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(c.debounce_ticks);
    @(posedge clk);
    cfg_index <= CFG_HOLDOFF;
    cfg_wdata <= CFG_DATA_W'(c.button_holdoff_ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings = c;
  endtask

  task automatic test_duty_map();
    send_tick(make_tick(0, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_IDLE, 1'b0));
    send_tick(make_tick(2, 1'b1, LK_CLOSED, 1'b1, 1'b1, ST_LOCK, 1'b1));
    send_tick(make_tick(3, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b0));
    send_tick(make_tick(7, 1'b0, LK_CLOSED, 1'b0, 1'b1, ST_IDLE, 1'b0));
    send_tick(make_tick(8, 1'b0, LK_OPEN, 1'b0, 1'b1, ST_IDLE, 1'b0));
    send_tick(make_tick(9, 1'b0, LK_MOVING, 1'b1, 1'b0, ST_IDLE, 1'b0));
    send_tick(make_tick(10, 1'b0, LK_UNKNOWN, 1'b0, 1'b0, ST_IDLE, 1'b0));
    send_tick(make_tick(84, 1'b0, LK_CLOSED, 1'b1, 1'b0, ST_IDLE, 1'b0));
    send_tick(make_tick(85, 1'b0, LK_OPEN, 1'b1, 1'b1, ST_CHARGE, 1'b1));
    send_tick(make_tick(96, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b0));
    send_tick(make_tick(97, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b0));
    send_tick(make_tick(98, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b0));
    send_tick(make_tick(127, 1'b1, LK_UNKNOWN, 1'b1, 1'b1, STATE_W'(7), 1'b1));
  endtask

  task automatic test_request_codes();
    wait_drained();
    apply_settings(cfg_t'{1'b0, 1'b1, 1'b1, 4'd0, 8'd0});
    send_tick(make_tick(50, 1'b0, LK_OPEN, 1'b1, 1'b1, ST_IDLE, 1'b0));
    for (int code = 0; code < 8; code++)
      send_tick(make_tick(50, 1'b0, LOCK_W'(code % 4), 1'b1, 1'b1, STATE_W'(code), 1'b1));
    send_tick(make_tick(50, 1'b1, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b1));
    send_tick(make_tick(50, 1'b0, LK_CLOSED, 1'b1, 1'b1, ST_CHARGE, 1'b0));
  endtask

  task automatic test_backpressure();
    wait_drained();
    apply_settings(cfg_t'{1'b0, 1'b1, 1'b1, 4'd2, 8'd10});
    sender_gaps        = 1'b0;
    receiver_stalls    = 1'b0;
    result_hold_cycles = 80;
    for (int i = 0; i < 30; i++) send_tick(draw_tick(RUN_PWM));
    wait_drained();
    for (int i = 0; i < 10; i++) send_tick(draw_tick(RUN_PWM));
  endtask

  task automatic run_sessions(int budget);
    int sent;
    int len;
    int pick;
    int run_kind;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 9);
      run_kind = (pick < 6) ? RUN_PWM : (pick < 9) ? RUN_LOW : RUN_NOISE;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      if (len > budget - sent) len = budget - sent;
      sender_gaps     = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      for (int i = 0; i < len; i++)
        send_tick(draw_tick(($urandom_range(0, 19) == 0) ? RUN_NOISE : run_kind));
      sent = sent + len;
    end
  endtask

  task automatic test_random_settings();
    cfg_t c;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: c = cfg_t'{1'b1, 1'b1, 1'b1, 4'd0, 8'd0};
        1: c = cfg_t'{1'b0, 1'b1, 1'b0, 4'd0, 8'd254};
        2: c = cfg_t'{1'b1, 1'b0, 1'b1, 4'd15, 8'd0};
        3: c = cfg_t'{1'b0, 1'b0, 1'b0, 4'd15, 8'd254};
        default: c = cfg_t'{1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), DEB_W'($urandom_range(0, 15)),
                            HOLD_W'($urandom_range(0, 254))};
      endcase
      wait_drained();
      apply_settings(c);
      run_sessions((phase == 1) ? 300 : 65);
    end
  endtask

  initial begin
    mismatch_count     = 0;
    sender_gaps        = 1'b1;
    receiver_stalls    = 1'b1;
    result_hold_cycles = 0;
    settings           = cfg_t'{1'b0, 1'b1, 1'b1, DEBOUNCE_RST, HOLDOFF_RST};
    low_duty_ticks     = '0;
    pwm_ticks          = '0;
    ac_mode            = 1'b0;
    stop_block         = 1'b0;
    stop_timer         = '0;
    req_state          = ST_IDLE;
    act_state          = ST_IDLE;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_STANDALONE;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.duty_percent    <= '0;
    in_ch.button_held     <= 1'b0;
    in_ch.lock_status     <= LK_OPEN;
    in_ch.plug_detected   <= 1'b0;
    in_ch.dc_session_idle <= 1'b0;
    in_ch.charger_request <= ST_IDLE;
    in_ch.request_valid   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_duty_map();
    test_request_codes();
    test_backpressure();
    test_random_settings();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: ac_pilot_charge_controller.f
rtl/core/acpc_pkg.sv
rtl/core/acpc_if.sv
rtl/core/acpc_limit.sv
rtl/core/acpc_core.sv
rtl/core/ac_pilot_charge_controller.sv
dv/ac_pilot_charge_controller_test.sv
